[rtl/sfce_pkg.sv]
// Shared types and constants for the spline force curve evaluator.
// Used by sfce_div_pipe and spline_force_curve_eval_core; no dependencies.
package sfce_pkg;

    // Spline segments across full pedal travel
    localparam int SEGMENTS = 5;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_FORCE_POINTS  = 3'd0;
    localparam logic [2:0] CFG_CURVE_A_TERMS = 3'd1;
    localparam logic [2:0] CFG_CURVE_B_TERMS = 3'd2;
    localparam logic [2:0] CFG_FORCE_MINIMUM = 3'd3;
    localparam logic [2:0] CFG_FORCE_SPAN    = 3'd4;
    localparam logic [2:0] CFG_TRAVEL_STEPS  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // Reset values: points 0,20,40,60,80,100 percent
    localparam logic [47:0] FORCE_POINTS_RST = 48'h64_50_3C_28_14_00;
    localparam logic [19:0] TRAVEL_STEPS_RST = 20'd1;

    // Divider operand widths
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 39;

    // Fixed divisor of the normalized slope: percent scale with Q20 fraction
    localparam logic [DIV_DEN_W-1:0] NORM_DEN  = DIV_DEN_W'(100 * (2 ** 20));

    // Force scaling by 1/(100*2^24): half-unit rounding offset, positive bias
    // of 100*2^19 ahead of the reciprocal multiply, floor(x/100) = x*M >> 37
    localparam logic signed [DIV_NUM_W-1:0] FORCE_HALF = DIV_NUM_W'(50 * (2 ** 24));
    localparam int                          FORCE_BIAS_Q = 2 ** 19;
    localparam logic signed [DIV_NUM_W-1:0] FORCE_BIAS = DIV_NUM_W'(100 * FORCE_BIAS_Q);
    localparam logic [30:0]                 RECIP_100   = 31'h51EB_851F;
    localparam int                          RECIP_SHIFT = 37;

    typedef struct packed {
        logic signed [17:0] position;
        logic               slope_normalized;
    } in_item_t;

    typedef struct packed {
        logic signed [17:0] force_res;
        logic signed [31:0] slope;
    } out_item_t;

endpackage

[rtl/sfce_div_pipe.sv]
// Pipelined restoring divider: sat32(round_half_up(num / den)), den > 0.
// One quotient bit per bit stage; depends on sfce_pkg for operand widths.
module sfce_div_pipe (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic signed [sfce_pkg::DIV_NUM_W-1:0]  num,
    input  logic        [sfce_pkg::DIV_DEN_W-1:0]  den,
    output logic                                   out_vld,
    output logic signed [31:0]                     quo
);

    localparam int NPW = sfce_pkg::DIV_NUM_W + 2;   // 2*num + den
    localparam int RW  = NPW + 1;                   // magnitude width
    localparam int DW  = sfce_pkg::DIV_DEN_W + 1;   // 2*den
    localparam int CW  = DW + 32;                   // compare width

    logic            vld_reg [0:32];
    logic [RW-1:0]   rem_reg [0:32];
    logic [DW-1:0]   dd_reg  [0:32];
    logic            neg_reg [0:32];
    logic [31:0]     quo_reg [0:32];
    logic            ovf_reg [0:32];
    logic            out_vld_reg;
    logic [31:0]     out_quo_reg;

    // Floor division of 2n+d by 2d, folded onto a non-negative magnitude
    logic signed [NPW-1:0] nprime;
    logic [RW-1:0]         nx;
    logic [DW-1:0]         dd_next;
    logic [RW-1:0]         mag_next;

    always_comb begin
        nprime   = (NPW'(num) <<< 1) + $signed({{(NPW-sfce_pkg::DIV_DEN_W){1'b0}}, den});
        nx       = RW'(nprime);
        dd_next  = {den, 1'b0};
        mag_next = nprime[NPW-1] ? (RW'(0) - nx + RW'(dd_next) - RW'(1)) : nx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
        if (en) begin
            rem_reg[0] <= mag_next;
            dd_reg[0]  <= dd_next;
            neg_reg[0] <= nprime[NPW-1];
            quo_reg[0] <= '0;
            ovf_reg[0] <= 1'b0;
        end
    end

    // Bit stages: stage i resolves quotient bit 32-i, the first also overflow
    for (genvar i = 1; i <= 32; i++) begin : g_bit
        localparam int K = 32 - i;
        logic [CW-1:0] rem_x;
        logic [CW-1:0] sub_x;
        logic          ge;

        always_comb begin
            rem_x = CW'(rem_reg[i-1]);
            sub_x = CW'(dd_reg[i-1]) << K;
            ge    = rem_x >= sub_x;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            if (en) begin
                rem_reg[i] <= ge ? RW'(rem_x - sub_x) : rem_reg[i-1];
                dd_reg[i]  <= dd_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1]
                              | ((i == 1) && (rem_x >= (CW'(dd_reg[i-1]) << 32)));
                quo_reg[i] <= quo_reg[i-1] | (32'(ge) << K);
            end
        end
    end

    // Sign restore and saturation
    logic [31:0] sat_next;

    always_comb begin
        if (ovf_reg[32]) begin
            sat_next = neg_reg[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (neg_reg[32]) begin
            sat_next = (quo_reg[32] > 32'h8000_0000) ? 32'h8000_0000
                                                     : 32'(32'd0 - quo_reg[32]);
        end else begin
            sat_next = quo_reg[32][31] ? 32'h7FFF_FFFF : quo_reg[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[32];
        end
        if (en) begin
            out_quo_reg <= sat_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign quo     = $signed(out_quo_reg);

endmodule

[rtl/spline_force_curve_eval_core.sv]
// Top level of the spline force curve evaluator.
// Depends on sfce_pkg and sfce_div_pipe.
//
// Evaluates a five-segment cubic spline pedal force curve and its slope for
// each position beat. One beat is accepted per clock while the pipeline is not
// stalled. A beat passes through 42 register stages to m_valid: seven
// arithmetic stages, then the 34-stage restoring divider (one quotient bit
// per bit stage) that does the percent and travel scaling of the slope, then
// the output register. The force is scaled by a three-stage reciprocal
// multiply and delayed to line up with the slope. The whole pipeline stalls
// as a unit while a result waits on m_ready. Configuration writes are always
// accepted and must only be issued while the pipeline is empty.
module spline_force_curve_eval_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sfce_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sfce_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfce_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfce_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NW = sfce_pkg::DIV_NUM_W;
    localparam int DN = sfce_pkg::DIV_DEN_W;

    // Divider depth (34) less the three force scaling stages
    localparam int FORCE_DLY = 31;

    // Configuration registers
    logic [47:0] force_points_reg;
    logic [59:0] curve_a_terms_reg;
    logic [59:0] curve_b_terms_reg;
    logic [15:0] force_minimum_reg;
    logic [15:0] force_span_reg;
    logic [19:0] travel_steps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_points_reg  <= sfce_pkg::FORCE_POINTS_RST;
            curve_a_terms_reg <= '0;
            curve_b_terms_reg <= '0;
            force_minimum_reg <= '0;
            force_span_reg    <= '0;
            travel_steps_reg  <= sfce_pkg::TRAVEL_STEPS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sfce_pkg::CFG_FORCE_POINTS:  force_points_reg  <= cfg_data[47:0];
                sfce_pkg::CFG_CURVE_A_TERMS: curve_a_terms_reg <= cfg_data[59:0];
                sfce_pkg::CFG_CURVE_B_TERMS: curve_b_terms_reg <= cfg_data[59:0];
                sfce_pkg::CFG_FORCE_MINIMUM: force_minimum_reg <= cfg_data[15:0];
                sfce_pkg::CFG_FORCE_SPAN:    force_span_reg    <= cfg_data[15:0];
                sfce_pkg::CFG_TRAVEL_STEPS:  travel_steps_reg  <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Global advance: move when the output slot is free or being taken
    logic out_vld_reg;
    logic en;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // Stage 1: clamp, segment select, fraction
    logic [16:0] p_c;
    logic [18:0] u_c;
    logic [2:0]  seg_raw_c;
    logic [2:0]  seg_c;
    logic [5:0]  pt_idx_c;
    logic [5:0]  tm_idx_c;
    logic [16:0] t_c;
    logic [16:0] s_c;

    always_comb begin
        if (s_data.position[17]) begin
            p_c = '0;
        end else if (s_data.position > 18'sd65536) begin
            p_c = 17'h10000;
        end else begin
            p_c = s_data.position[16:0];
        end
        u_c       = 19'(p_c) * 19'(sfce_pkg::SEGMENTS);
        seg_raw_c = u_c[18:16];
        seg_c     = (seg_raw_c > 3'(sfce_pkg::SEGMENTS - 1)) ? 3'(sfce_pkg::SEGMENTS - 1)
                                                             : seg_raw_c;
        pt_idx_c  = {seg_c, 3'b000};
        tm_idx_c  = 6'(seg_c) * 6'd12;
        t_c       = 17'(u_c - {seg_c, 16'h0000});
        s_c       = 17'(18'h10000 - {1'b0, t_c});
    end

    logic        s1_vld_reg;
    logic        s1_norm_reg;
    logic [16:0] s1_t_reg;
    logic [16:0] s1_s_reg;
    logic [7:0]  s1_y0_reg;
    logic [7:0]  s1_y1_reg;
    logic [11:0] s1_a_reg;
    logic [11:0] s1_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
        end
        if (en) begin
            s1_norm_reg <= s_data.slope_normalized;
            s1_t_reg    <= t_c;
            s1_s_reg    <= s_c;
            s1_y0_reg   <= force_points_reg[pt_idx_c +: 8];
            s1_y1_reg   <= force_points_reg[pt_idx_c + 6'd8 +: 8];
            s1_a_reg    <= curve_a_terms_reg[tm_idx_c +: 12];
            s1_b_reg    <= curve_b_terms_reg[tm_idx_c +: 12];
        end
    end

    // Stage 2: basis products and differences
    logic               s2_vld_reg;
    logic               s2_norm_reg;
    logic signed [29:0] s2_as_reg;
    logic signed [29:0] s2_bt_reg;
    logic [24:0]        s2_sy0_reg;
    logic [24:0]        s2_ty1_reg;
    logic [30:0]        s2_ts_reg;
    logic signed [17:0] s2_smt_reg;
    logic signed [12:0] s2_dba_reg;
    logic signed [8:0]  s2_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
        if (en) begin
            s2_norm_reg <= s1_norm_reg;
            s2_as_reg   <= $signed(s1_a_reg) * $signed({1'b0, s1_s_reg});
            s2_bt_reg   <= $signed(s1_b_reg) * $signed({1'b0, s1_t_reg});
            s2_sy0_reg  <= s1_s_reg * s1_y0_reg;
            s2_ty1_reg  <= s1_t_reg * s1_y1_reg;
            s2_ts_reg   <= 31'(s1_t_reg) * 31'(s1_s_reg);
            s2_smt_reg  <= $signed({1'b0, s1_s_reg}) - $signed({1'b0, s1_t_reg});
            s2_dba_reg  <= $signed({s1_b_reg[11], s1_b_reg}) - $signed({s1_a_reg[11], s1_a_reg});
            s2_dy_reg   <= $signed({1'b0, s1_y1_reg}) - $signed({1'b0, s1_y0_reg});
        end
    end

    // Stage 3: cubic weight a*s + b*t and linear part
    logic               s3_vld_reg;
    logic               s3_norm_reg;
    logic signed [29:0] s3_ab_reg;
    logic [24:0]        s3_lin_reg;
    logic [30:0]        s3_ts_reg;
    logic signed [17:0] s3_smt_reg;
    logic signed [12:0] s3_dba_reg;
    logic signed [8:0]  s3_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
        if (en) begin
            s3_norm_reg <= s2_norm_reg;
            s3_ab_reg   <= s2_as_reg + s2_bt_reg;
            s3_lin_reg  <= s2_sy0_reg + s2_ty1_reg;
            s3_ts_reg   <= s2_ts_reg;
            s3_smt_reg  <= s2_smt_reg;
            s3_dba_reg  <= s2_dba_reg;
            s3_dy_reg   <= s2_dy_reg;
        end
    end

    // Stage 4: curve and derivative products
    logic               s4_vld_reg;
    logic               s4_norm_reg;
    logic signed [61:0] s4_tsab_reg;
    logic signed [47:0] s4_smtab_reg;
    logic signed [44:0] s4_tsdba_reg;
    logic [24:0]        s4_lin_reg;
    logic signed [8:0]  s4_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= s3_vld_reg;
        end
        if (en) begin
            s4_norm_reg  <= s3_norm_reg;
            s4_tsab_reg  <= $signed({1'b0, s3_ts_reg}) * s3_ab_reg;
            s4_smtab_reg <= s3_smt_reg * s3_ab_reg;
            s4_tsdba_reg <= $signed({1'b0, s3_ts_reg}) * s3_dba_reg;
            s4_lin_reg   <= s3_lin_reg;
            s4_dy_reg    <= s3_dy_reg;
        end
    end

    // Stage 5: Y52 and D36 sums
    logic               s5_vld_reg;
    logic               s5_norm_reg;
    logic signed [63:0] s5_y52_reg;
    logic signed [47:0] s5_d36_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= s4_vld_reg;
        end
        if (en) begin
            s5_norm_reg <= s4_norm_reg;
            s5_y52_reg  <= $signed({3'b000, s4_lin_reg, 36'h0}) + 64'(s4_tsab_reg);
            s5_d36_reg  <= 48'($signed({s4_dy_reg, 36'h0})) + s4_smtab_reg
                           + 48'(s4_tsdba_reg);
        end
    end

    // Stage 6: rounding to Q24 and times SEGMENTS
    logic signed [63:0] y52_rnd_c;
    logic signed [47:0] d36_rnd_c;
    logic signed [35:0] d24_c;

    always_comb begin
        y52_rnd_c = s5_y52_reg + 64'sh800_0000;
        d36_rnd_c = s5_d36_reg + 48'sh800;
        d24_c     = 36'(d36_rnd_c >>> 12);
    end

    logic               s6_vld_reg;
    logic               s6_norm_reg;
    logic signed [34:0] s6_y24_reg;
    logic signed [50:0] s6_d36x_reg;
    logic signed [38:0] s6_d24x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_vld_reg <= 1'b0;
        end else if (en) begin
            s6_vld_reg <= s5_vld_reg;
        end
        if (en) begin
            s6_norm_reg <= s5_norm_reg;
            s6_y24_reg  <= 35'(y52_rnd_c >>> 28);
            s6_d36x_reg <= 51'(s5_d36_reg) * 51'(sfce_pkg::SEGMENTS);
            s6_d24x_reg <= 39'(d24_c) * 39'(sfce_pkg::SEGMENTS);
        end
    end

    // Stage 7: span products and divisor select
    logic [19:0] travel_c;
    logic [26:0] travel100_c;

    always_comb begin
        travel_c    = (travel_steps_reg == '0) ? 20'd1 : travel_steps_reg;
        travel100_c = 27'(travel_c) * 27'd100;
    end

    logic                 s7_vld_reg;
    logic signed [NW-1:0] s7_fnum_reg;
    logic signed [NW-1:0] s7_snum_reg;
    logic [DN-1:0]        s7_sden_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (en) begin
            s7_vld_reg <= s6_vld_reg;
        end
        if (en) begin
            s7_fnum_reg <= NW'(s6_y24_reg) * NW'($signed({1'b0, force_span_reg}));
            if (s6_norm_reg) begin
                s7_snum_reg <= NW'(s6_d36x_reg);
                s7_sden_reg <= sfce_pkg::NORM_DEN;
            end else begin
                s7_snum_reg <= NW'(s6_d24x_reg) * NW'($signed({1'b0, force_span_reg}));
                s7_sden_reg <= {travel100_c, 12'h000};
            end
        end
    end

    // Slope scaling divider
    logic               sdiv_vld;
    logic signed [31:0] sdiv_quo;

    sfce_div_pipe u_slope_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s7_vld_reg),
        .num     (s7_snum_reg),
        .den     (s7_sden_reg),
        .out_vld (sdiv_vld),
        .quo     (sdiv_quo)
    );

    // Force stage A: round off Q24, bias positive (|value| stays below 2^25)
    logic signed [NW-1:0] fr_sum_c;
    logic signed [NW-1:0] fr_x_c;
    logic [26:0]          f1_x_reg;

    always_comb begin
        fr_sum_c = s7_fnum_reg + sfce_pkg::FORCE_HALF;
        fr_x_c   = (fr_sum_c >>> 24) + sfce_pkg::FORCE_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_x_reg <= fr_x_c[26:0];
        end
    end

    // Force stage B: reciprocal multiply for the divide by 100
    logic [57:0] f2_prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_prod_reg <= 58'(f1_x_reg) * 58'(sfce_pkg::RECIP_100);
        end
    end

    // Force stage C: remove bias, add force minimum, saturate to 18 bits
    logic [20:0]        force_q_c;
    logic signed [23:0] force_sum_c;
    logic signed [17:0] force_sat_c;
    logic signed [17:0] f3_force_reg;

    always_comb begin
        force_q_c   = 21'(f2_prod_reg >> sfce_pkg::RECIP_SHIFT);
        force_sum_c = $signed({3'b000, force_q_c}) - 24'(sfce_pkg::FORCE_BIAS_Q)
                      + $signed({8'h00, force_minimum_reg});
        if (force_sum_c > 24'sd131071) begin
            force_sat_c = 18'sd131071;
        end else if (force_sum_c < -24'sd131072) begin
            force_sat_c = -18'sd131072;
        end else begin
            force_sat_c = force_sum_c[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_force_reg <= force_sat_c;
        end
    end

    // Force delay line, aligned with the slope divider output
    logic signed [17:0] fdly_reg [1:FORCE_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            fdly_reg[1] <= f3_force_reg;
            for (int k = 2; k <= FORCE_DLY; k++) begin
                fdly_reg[k] <= fdly_reg[k-1];
            end
        end
    end

    // Output stage
    sfce_pkg::out_item_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= sdiv_vld;
        end
        if (en) begin
            out_data_reg.force_res <= fdly_reg[FORCE_DLY];
            out_data_reg.slope     <= sdiv_quo;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // A waiting result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while waiting");

    // A stall freezes the front pipeline occupancy
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg,
                         s5_vld_reg, s6_vld_reg, s7_vld_reg}))
        else $error("front pipeline moved during a stall");

    // A result held for the consumer must come from a beat that left the divider
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && sdiv_vld) |=> m_valid)
        else $error("divider beat lost at the output stage");

endmodule

[test/testbench.sv]
// Self-checking testbench for spline_force_curve_eval_core.
// Depends on sfce_pkg and the core RTL; predicts force and slope per beat.
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
    localparam int         WATCHDOG_MAX   = 5000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         LONG_HOLD      = 200;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    sfce_pkg::in_item_t              s_data = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    sfce_pkg::out_item_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sfce_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfce_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the curve registers
    logic [47:0] points_r  = sfce_pkg::FORCE_POINTS_RST;
    logic [59:0] a_terms_r = '0;
    logic [59:0] b_terms_r = '0;
    logic [15:0] min_r     = '0;
    logic [15:0] span_r    = '0;
    logic [19:0] travel_r  = sfce_pkg::TRAVEL_STEPS_RST;

    sfce_pkg::in_item_t  position_q[$];
    sfce_pkg::out_item_t curve_exp_q[$];
    int        cfg_beats = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        gaps_on = 1'b1;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_asked = 0;
    int        hold_done = 0;

    spline_force_curve_eval_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 aclk = ~aclk;

    // floor division and round-half-up division, positive divisor
    function automatic longint div_down(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint div_half_up(longint n, longint d);
        return div_down(2 * n + d, 2 * d);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Spline force and gradient for one pedal position
    function automatic sfce_pkg::out_item_t curve_eval(sfce_pkg::in_item_t it);
        sfce_pkg::out_item_t r;
        longint p, u, seg, t, s, y0, y1, a, b, ab, ts;
        longint y52, y24, frc, d36, d24, slp, trav;
        p = clip(longint'(it.position), 0, 65536);
        u = p * sfce_pkg::SEGMENTS;
        seg = u >>> 16;
        if (seg > sfce_pkg::SEGMENTS - 1) seg = sfce_pkg::SEGMENTS - 1;
        t = u - seg * 65536;
        s = 65536 - t;
        y0 = longint'(points_r[8*seg +: 8]);
        y1 = longint'(points_r[8*(seg+1) +: 8]);
        a = longint'($signed(a_terms_r[12*seg +: 12]));
        b = longint'($signed(b_terms_r[12*seg +: 12]));
        ab = a * s + b * t;
        ts = t * s;
        y52 = (s * y0 + t * y1) * (64'sd1 << 36) + ts * ab;
        y24 = div_half_up(y52, 64'sd1 << 28);
        frc = longint'(min_r) + div_half_up(y24 * longint'(span_r), 100 * (64'sd1 << 24));
        frc = clip(frc, -131072, 131071);
        d36 = (y1 - y0) * (64'sd1 << 36) + (s - t) * ab + ts * (b - a);
        if (it.slope_normalized) begin
            slp = div_half_up(d36 * sfce_pkg::SEGMENTS, 100 * (64'sd1 << 20));
        end else begin
            d24 = div_half_up(d36, 64'sd1 << 12);
            trav = (travel_r == 0) ? 1 : longint'(travel_r);
            slp = div_half_up(d24 * sfce_pkg::SEGMENTS * longint'(span_r),
                              100 * trav * (64'sd1 << 12));
        end
        slp = clip(slp, -64'sd2147483648, 64'sd2147483647);
        r.force_res = frc[17:0];
        r.slope = slp[31:0];
        return r;
    endfunction

    // Input driver: random gap bursts, prediction on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) curve_exp_q.push_back(curve_eval(s_data));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (position_q.size() > 0) begin
                    s_data <= position_q.pop_front();
                    s_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: stall bursts and one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_asked;
            recv_gap <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        sfce_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (curve_exp_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat: %p", m_data);
            end else begin
                want = curve_exp_q.pop_front();
                if (want.force_res !== m_data.force_res || want.slope !== m_data.slope) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp force %0d slope %0d, got force %0d slope %0d",
                                 want.force_res, want.slope, m_data.force_res, m_data.slope);
                end
            end
        end
    end

    // Register writes land in the local copy when accepted
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            cfg_beats <= cfg_beats + 1;
            case (cfg_index)
                sfce_pkg::CFG_FORCE_POINTS:  points_r  <= cfg_data[47:0];
                sfce_pkg::CFG_CURVE_A_TERMS: a_terms_r <= cfg_data[59:0];
                sfce_pkg::CFG_CURVE_B_TERMS: b_terms_r <= cfg_data[59:0];
                sfce_pkg::CFG_FORCE_MINIMUM: min_r     <= cfg_data[15:0];
                sfce_pkg::CFG_FORCE_SPAN:    span_r    <= cfg_data[15:0];
                sfce_pkg::CFG_TRAVEL_STEPS:  travel_r  <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("[spline_force_curve_eval_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
        int target;
        target = cfg_beats + 1;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_beats == target);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [47:0] pts, input logic [59:0] at,
                             input logic [59:0] bt, input logic [15:0] mn,
                             input logic [15:0] sp, input logic [19:0] tr);
        write_reg(sfce_pkg::CFG_FORCE_POINTS, 60'(pts));
        write_reg(sfce_pkg::CFG_CURVE_A_TERMS, at);
        write_reg(sfce_pkg::CFG_CURVE_B_TERMS, bt);
        write_reg(sfce_pkg::CFG_FORCE_MINIMUM, 60'(mn));
        write_reg(sfce_pkg::CFG_FORCE_SPAN, 60'(sp));
        write_reg(sfce_pkg::CFG_TRAVEL_STEPS, 60'(tr));
    endtask

    task automatic push_pos(input int pos, input bit norm);
        sfce_pkg::in_item_t it;
        it.position = pos[17:0];
        it.slope_normalized = norm;
        position_q.push_back(it);
    endtask

    // Mostly in-range positions, some over the whole 18-bit field
    task automatic push_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                push_pos(int'($urandom()), 1'($urandom_range(0, 1)));
            else
                push_pos(int'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        wait (position_q.size() == 0 && !s_valid && curve_exp_q.size() == 0);
        repeat (5) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset curve: clamps, segment edges, both slope modes
        push_pos(-131072, 1); push_pos(-1, 0); push_pos(0, 1); push_pos(1, 0);
        push_pos(13107, 1); push_pos(13108, 0); push_pos(26214, 1);
        push_pos(32768, 0); push_pos(52428, 1); push_pos(52429, 0);
        push_pos(65535, 1); push_pos(65536, 0); push_pos(65537, 1);
        push_pos(131071, 0);
        drain();

        // Full-scale minimum and span with nonzero terms
        write_all(48'({$urandom(), $urandom()}), 60'({$urandom(), $urandom()}),
                  60'({$urandom(), $urandom()}), 16'hFFFF, 16'hFFFF, 20'd1);
        push_pos(0, 0); push_pos(65536, 0); push_pos(6553, 1); push_pos(39321, 0);
        push_random(6);
        drain();

        // Random curves
        repeat (5) begin
            write_all(48'({$urandom(), $urandom()}), 60'({$urandom(), $urandom()}),
                      60'({$urandom(), $urandom()}), 16'($urandom_range(0, 4000)),
                      16'($urandom()), 20'($urandom_range(1, 20'hFFFFF)));
            write_reg(CFG_UNUSED_IDX, 60'({$urandom(), $urandom()}));
            if ($urandom_range(0, 1)) hold_asked <= hold_asked + 1;
            push_random(110);
            drain();
        end

        // Extremes: points at 255 and at 0, largest terms, zero and full travel
        write_all(48'hFFFF_FFFF_FFFF, {5{12'h7FF}}, {5{12'h800}}, 16'hFFFF, 16'hFFFF, 20'd0);
        hold_asked <= hold_asked + 1;
        push_random(60);
        drain();
        write_all(48'h0, {5{12'h800}}, {5{12'h7FF}}, 16'h0, 16'hFFFF, 20'hFFFFF);
        push_random(60);
        drain();

        // Last stretch without gaps
        write_all(48'({$urandom(), $urandom()}), 60'({$urandom(), $urandom()}),
                  60'({$urandom(), $urandom()}), 16'($urandom()), 16'($urandom()),
                  20'($urandom_range(1, 5000)));
        gaps_on = 1'b0;
        push_random(50);
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && curve_exp_q.size() == 0)
            $display("[spline_force_curve_eval_core] OK");
        else
            $display("[spline_force_curve_eval_core] ERROR");
        $finish;
    end

endmodule
